// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the morphology RTL; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted
`define BDDE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define BDDE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define BDDE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define BDDE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/bdde_pkg.sv
// ----------------------------------------------------------------------------
// bdde_pkg
// Types and constants of the binary diamond dilate/erode block.
// ----------------------------------------------------------------------------
package bdde_pkg;

  // Register field widths and reset values
  localparam int DIM_W = 12;
  localparam logic             MODE_RST   = 1'b0;
  localparam logic [DIM_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 12'd480;
  localparam logic [DIM_W-1:0] MIN_DIM    = 12'd5;

  // Mode codes
  localparam logic MODE_DILATE = 1'b0;
  localparam logic MODE_ERODE  = 1'b1;

  // Pixel levels that count as a hit
  localparam logic [7:0] HIT_LEVEL  = 8'd255;
  localparam logic [7:0] MISS_LEVEL = 8'd0;

  // Window geometry
  localparam int BORDER     = 2;
  localparam int WIN_ROWS   = 5;
  localparam int WIN_COLS   = 5;
  localparam int ROW_STORES = 4;
  // A row-store bit k is real only once in_row + k reaches this value
  localparam int KEEP_ROW   = 6;

  // Diamond taps per window column, index 0 is the oldest column
  localparam logic [WIN_ROWS-1:0] DIAMOND_COL [WIN_COLS] = '{
    5'b00100, 5'b01110, 5'b11111, 5'b01110, 5'b00100
  };

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } bdde_cfg_idx_t;

  // Channel payloads
  typedef struct packed {
    logic [7:0] red_level;
    logic       is_padding;
  } bdde_in_t;

  typedef struct packed {
    logic white;
    logic last_of_frame;
  } bdde_out_t;

  // Position status handed from the position tracker to the datapath
  typedef struct packed {
    logic                  past;
    logic                  hit_zone;
    logic [ROW_STORES-1:0] row_keep;
    logic                  emit;
    logic                  last;
  } bdde_pos_t;

endpackage

// File: rtl/bdde_ram.sv
// ----------------------------------------------------------------------------
// bdde_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bdde_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/bdde_cell.sv
// ----------------------------------------------------------------------------
// bdde_cell
// One window column: holds five hit bits and passes them to the older cell.
// ----------------------------------------------------------------------------
module bdde_cell
  import bdde_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                shift,
  input  logic                clear,
  input  logic [WIN_ROWS-1:0] data_i,
  input  logic [WIN_ROWS-1:0] mask_i,
  output logic [WIN_ROWS-1:0] data_o,
  output logic                any_o
);

  logic [WIN_ROWS-1:0] bits_r;
  logic [WIN_ROWS-1:0] bits_nxt;

  // Clear wins over a shift in the same cycle
  always_comb begin
    bits_nxt = bits_r;
    if (clear) begin
      bits_nxt = '0;
    end else if (shift) begin
      bits_nxt = data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= '0;
    end else begin
      bits_r <= bits_nxt;
    end
  end

  assign data_o = bits_r;
  // Diamond taps on the column this cell takes at the next shift
  assign any_o  = |(data_i & mask_i);

endmodule

// File: rtl/bdde_pos.sv
// ----------------------------------------------------------------------------
// bdde_pos
// Input and output raster position tracking and border/flush decisions.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bdde_pos
  import bdde_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step,
  input  logic                             restart,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]   w_eff,
  input  logic [DIM_W-1:0]                 h_eff,
  output logic [$clog2(MAX_WIDTH)-1:0]     col_o,
  output logic [$clog2(MAX_WIDTH)-1:0]     col_nxt_o,
  output logic                             frame_end_o,
  output bdde_pos_t                        status_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  // Rows run up to two past the frame while flushing
  localparam int RW = DIM_W + 1;

  logic [CW-1:0]    in_column_r, in_column_nxt;
  logic [RW-1:0]    in_row_r, in_row_nxt;
  logic [CW-1:0]    out_col_r, out_col_nxt;
  logic [DIM_W-1:0] out_row_r, out_row_nxt;

  logic [WW-1:0] col_w;
  logic [WW-1:0] out_col_w;
  logic [RW-1:0] h_ext;
  logic          col_wrap;
  logic          out_col_wrap;
  logic          frame_end;
  bdde_pos_t     status;

  assign col_w     = WW'(in_column_r);
  assign out_col_w = WW'(out_col_r);
  assign h_ext     = RW'(h_eff);
  assign col_wrap     = (col_w == w_eff - WW'(1));
  assign out_col_wrap = (out_col_w == w_eff - WW'(1));

  // Status of the item now at the input
  always_comb begin
    status.past = (in_row_r >= h_ext);
    status.hit_zone = !status.past
                    && (col_w >= WW'(BORDER)) && (col_w < w_eff - WW'(BORDER))
                    && (in_row_r >= RW'(BORDER)) && (in_row_r < h_ext - RW'(BORDER));
    for (int k = 0; k < ROW_STORES; k++) begin
      status.row_keep[k] = (in_row_r >= RW'(KEEP_ROW - k));
    end
    // Linear input position at least two rows plus two pixels
    status.emit = (in_row_r > RW'(BORDER))
                || ((in_row_r == RW'(BORDER)) && (col_w >= WW'(BORDER)));
    status.last = (out_row_r == h_eff - DIM_W'(1)) && out_col_wrap;
  end

  assign frame_end = step && status.emit && status.last;

  // Input position
  always_comb begin
    in_column_nxt = in_column_r;
    in_row_nxt    = in_row_r;
    if (restart || frame_end) begin
      in_column_nxt = '0;
      in_row_nxt    = '0;
    end else if (step) begin
      if (col_wrap) begin
        in_column_nxt = '0;
        in_row_nxt    = in_row_r + RW'(1);
      end else begin
        in_column_nxt = in_column_r + CW'(1);
      end
    end
  end

  // Output position
  always_comb begin
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (restart || frame_end) begin
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (step && status.emit) begin
      if (out_col_wrap) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + DIM_W'(1);
      end else begin
        out_col_nxt = out_col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_column_r <= '0;
      in_row_r    <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
    end else begin
      in_column_r <= in_column_nxt;
      in_row_r    <= in_row_nxt;
      out_col_r   <= out_col_nxt;
      out_row_r   <= out_row_nxt;
    end
  end

  assign col_o       = in_column_r;
  assign col_nxt_o   = in_column_nxt;
  assign frame_end_o = frame_end;
  assign status_o    = status;

  // Checks
  `BDDE_ASSERT_NEXT(a_frame_restart, clk, rst_n, frame_end, ~|{in_column_r, in_row_r, out_row_r})
  `BDDE_ASSERT_IMPLY(a_col_in_range, clk, rst_n, 1'b1, col_w < w_eff)
  `BDDE_ASSERT_IMPLY(a_row_bound, clk, rst_n, 1'b1, in_row_r <= h_ext + RW'(BORDER))
  `BDDE_ASSERT_IMPLY(a_out_row_bound, clk, rst_n, 1'b1, out_row_r < h_eff)

endmodule

// File: rtl/binary_diamond_dilate_erode_top.sv
// ----------------------------------------------------------------------------
// binary_diamond_dilate_erode_top
// Streaming 5x5 diamond dilate/erode of a binary raster image.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_data) takes one pixel request per
//   cycle in raster order: red level plus a padding flag. Padding inside the
//   frame is dropped; after the frame's last pixel, requests flush results.
//   Result channel (out_valid/out_stall/out_data) returns one pixel per
//   request once two rows plus two pixels have gone in; last_of_frame marks
//   the final pixel, after which the next request starts a new frame.
//   Result for a pixel shows on out_valid the cycle after the request two
//   rows plus two pixels later in raster order is taken. Sustained rate: one
//   pixel per clock while out_stall is low, set by the single read and
//   write port of the four-row line store, one column each.
//   Config port (cfg_valid/cfg_ready/cfg_index/cfg_wdata) is always ready;
//   register 0 mode, 1 width, 2 height; a write to one restarts the frame.
//   Reset loads mode dilate, 640x480 and restarts the frame; the line store
//   needs no clearing pass, its stale rows are masked on the first rows.
//   While a result is held under out_stall, in_stall is raised so nothing
//   is lost.
// ----------------------------------------------------------------------------
module binary_diamond_dilate_erode_top
  import bdde_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // pixel input
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bdde_in_t             in_data,
  // result output
  output logic                 out_valid,
  input  logic                 out_stall,
  output bdde_out_t            out_data,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_wdata
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  // Configuration registers
  logic             mode_r, mode_nxt;
  logic [DIM_W-1:0] width_r, width_nxt;
  logic [DIM_W-1:0] height_r, height_nxt;
  logic             cfg_we;
  logic             restart;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_comb begin
    mode_nxt   = mode_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    restart    = 1'b0;
    if (cfg_we) begin
      unique case (bdde_cfg_idx_t'(cfg_index))
        CFG_MODE: begin
          mode_nxt = cfg_wdata[0];
          restart  = 1'b1;
        end
        CFG_WIDTH: begin
          width_nxt = cfg_wdata;
          restart   = 1'b1;
        end
        CFG_HEIGHT: begin
          height_nxt = cfg_wdata;
          restart    = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_RST;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else begin
      mode_r   <= mode_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  // Effective frame size, saturated to the supported range
  logic [WW-1:0]    w_eff;
  logic [DIM_W-1:0] h_eff;

  always_comb begin
    if (width_r < MIN_DIM) begin
      w_eff = WW'(MIN_DIM);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_r);
    end
    h_eff = (height_r < MIN_DIM) ? MIN_DIM : height_r;
  end

  // Input handshake
  logic      accept;
  logic      step;
  logic      produce;
  logic      frame_end;
  bdde_pos_t status;
  logic [CW-1:0] col;
  logic [CW-1:0] col_nxt;

  logic      out_valid_r, out_valid_nxt;
  bdde_out_t out_data_r, out_data_nxt;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  // Padding inside the frame is taken but does nothing
  assign step     = accept && !(in_data.is_padding && !status.past);
  assign produce  = step && status.emit;

  bdde_pos #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_pos (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .restart     (restart),
    .w_eff       (w_eff),
    .h_eff       (h_eff),
    .col_o       (col),
    .col_nxt_o   (col_nxt),
    .frame_end_o (frame_end),
    .status_o    (status)
  );

  // Line store: one word per column, four rows above the input row
  logic [ROW_STORES-1:0] store_rd;
  logic [WIN_ROWS-1:0]   vec;
  logic                  hit;

  bdde_ram #(
    .WIDTH (ROW_STORES),
    .DEPTH (MAX_WIDTH)
  ) u_rows (
    .clk   (clk),
    .we    (step),
    .waddr (col),
    .wdata (vec[WIN_ROWS-1:1]),
    .raddr (col_nxt),
    .rdata (store_rd)
  );

  // New window column: stored rows (masked near the top) plus this hit
  assign hit = status.hit_zone
             && (in_data.red_level == ((mode_r == MODE_ERODE) ? MISS_LEVEL : HIT_LEVEL));
  assign vec = {hit, store_rd & status.row_keep};

  // Window as a chain of column cells, newest column at the top index
  logic [WIN_ROWS-1:0] cell_data [WIN_COLS];
  logic [WIN_COLS-1:0] cell_any;
  logic                win_clear;

  assign win_clear = restart || frame_end;

  for (genvar j = 0; j < WIN_COLS; j++) begin : g_cell
    logic [WIN_ROWS-1:0] feed;
    if (j == WIN_COLS - 1) begin : g_head
      assign feed = vec;
    end else begin : g_link
      assign feed = cell_data[j+1];
    end
    bdde_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .shift  (step),
      .clear  (win_clear),
      .data_i (feed),
      .mask_i (DIAMOND_COL[j]),
      .data_o (cell_data[j]),
      .any_o  (cell_any[j])
    );
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (produce) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.white         = (|cell_any) ^ (mode_r == MODE_ERODE);
      out_data_nxt.last_of_frame = status.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams binary frames through the diamond dilate/erode block and checks
// every output pixel against an in-bench model of the line stores, the 5x5
// hit window and the frame counters. Covers saturated and extreme frame
// sizes, padding in and after the frame, and register writes between runs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
  import bdde_pkg::*;
();

  localparam int LINE_W        = 2048;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int RAND_ITEMS    = 1200;
  localparam int CYCLE_LIMIT   = 1000000;
  // index past the last register: the block must ignore it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // Model of the filter: line stores, hit window, positions, pending pixels
  class diamond_tracker #(int LINE_LEN = 2048);
    logic                       mode_bit;
    logic [DIM_W-1:0]           width_word;
    logic [DIM_W-1:0]           height_word;
    bit                         line_bits [ROW_STORES][LINE_LEN];
    bit [WIN_ROWS*WIN_COLS-1:0] window;
    bit [WIN_ROWS*WIN_COLS-1:0] diamond;
    int unsigned                next_col, next_row, out_index;
    bdde_out_t                  expected_px[$];
    int unsigned                used_count, result_count, errors;

    function new();
      int dc, dr;
      mode_bit    = MODE_RST;
      width_word  = WIDTH_RST;
      height_word = HEIGHT_RST;
      used_count   = 0;
      result_count = 0;
      errors       = 0;
      restart();
      // taps within Manhattan distance 2 of the window center
      diamond = '0;
      for (int c = 0; c < WIN_COLS; c++) begin
        for (int r = 0; r < WIN_ROWS; r++) begin
          dc = c - 2;
          dr = r - 2;
          if ((dc < 0 ? -dc : dc) + (dr < 0 ? -dr : dr) <= 2)
            diamond[c*WIN_ROWS + r] = 1'b1;
        end
      end
    endfunction

    function void restart();
      next_col  = 0;
      next_row  = 0;
      out_index = 0;
      window    = '0;
    endfunction

    function int unsigned frame_cols();
      if (width_word < MIN_DIM) return MIN_DIM;
      if (width_word > LINE_LEN) return LINE_LEN;
      return width_word;
    endfunction

    function int unsigned frame_rows();
      return (height_word < MIN_DIM) ? MIN_DIM : height_word;
    endfunction

    function int unsigned pending();
      return expected_px.size();
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
      case (idx)
        CFG_MODE:   mode_bit = value[0];
        CFG_WIDTH:  width_word = value;
        CFG_HEIGHT: height_word = value;
        default:    return;
      endcase
      restart();
    endfunction

    // One accepted pixel request: update state, queue the output it releases
    function void take_request(bdde_in_t px);
      int unsigned w, h, pos;
      bit          past, hit, white, last;
      bit [4:0]    vec;
      bdde_out_t   res;
      w = frame_cols();
      h = frame_rows();
      past = next_row >= h;
      // padding inside the frame is dropped
      if (px.is_padding && !past) return;
      used_count++;

      hit = 1'b0;
      if (!past && next_col >= BORDER && next_col < w - BORDER &&
          next_row >= BORDER && next_row < h - BORDER)
        hit = px.red_level == ((mode_bit == MODE_ERODE) ? MISS_LEVEL : HIT_LEVEL);

      // stored rows above the input row, masked until rewritten this frame
      for (int k = 0; k < ROW_STORES; k++)
        vec[k] = (next_row + k < KEEP_ROW) ? 1'b0 : line_bits[k][next_col];
      vec[4] = hit;
      for (int k = 0; k < ROW_STORES; k++)
        line_bits[k][next_col] = vec[k+1];
      window = {vec, window[WIN_ROWS*WIN_COLS-1:WIN_ROWS]};

      pos = next_row * w + next_col;
      next_col++;
      if (next_col >= w) begin
        next_col = 0;
        next_row++;
      end
      if (pos < 2*w + 2) return;

      white = |(window & diamond);
      if (mode_bit == MODE_ERODE) white = !white;
      last = out_index >= w*h - 1;
      res.white = white;
      res.last_of_frame = last;
      expected_px.push_back(res);
      if (last) restart();
      else out_index++;
    endfunction

    task report_error(string what);
      if (errors < 40) $display("ERROR at result %0d: %s", result_count, what);
      errors++;
    endtask

    task check_result(bdde_out_t got);
      bdde_out_t want;
      if (expected_px.size() == 0) begin
        report_error("output pixel with no request pending");
      end else begin
        want = expected_px.pop_front();
        if (got.white !== want.white)
          report_error($sformatf("white expected %0d got %0d", want.white, got.white));
        if (got.last_of_frame !== want.last_of_frame)
          report_error($sformatf("last_of_frame expected %0d got %0d",
                                 want.last_of_frame, got.last_of_frame));
      end
      result_count++;
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  bdde_in_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  bdde_out_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_wdata;

  diamond_tracker #(LINE_W) sb;
  int unsigned gap_odds;
  bit          calm;
  bit          squeeze;
  int unsigned cycle_count;

  binary_diamond_dilate_erode_top #(.MAX_WIDTH(LINE_W)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  // Monitor: results first, then the request taken at the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (in_valid && !in_stall) sb.take_request(in_data);
    end
  end

  // Result side: random stall bursts, quiet stretches, one long hold-off
  initial begin
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (squeeze) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        squeeze = 1'b0;
      end else if (!calm && $urandom_range(0, 31) == 0) begin
        repeat ($urandom_range(20, 100)) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
    end
  end

  // Mostly hit/miss levels, with near misses and random levels mixed in
  function automatic logic [7:0] pick_red();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return MISS_LEVEL;
      4, 5, 6, 7: return HIT_LEVEL;
      8:          return $urandom_range(0, 1) ? 8'd254 : 8'd1;
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one pixel request; valid stays high on return
  task automatic send_pixel(input logic [7:0] red, input logic pad);
    if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{red_level: red, is_padding: pad};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Full frame plus flush, or cut short at a random point
  task automatic send_frame(input bit cut_short);
    int unsigned w, h, n, stop;
    w = sb.frame_cols();
    h = sb.frame_rows();
    n = w * h;
    stop = cut_short ? $urandom_range(1, n + 2*w) : n + 2*w + 2;
    for (int unsigned i = 0; i < stop; i++) begin
      if (i < n) begin
        if ($urandom_range(0, 19) == 0) send_pixel(pick_red(), 1'b1);
        send_pixel(pick_red(), 1'b0);
      end else begin
        // a real pixel past the frame acts as padding
        send_pixel(pick_red(), $urandom_range(0, 5) != 0);
      end
    end
  endtask

  // Register write; valid stays high on return
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_register(idx, value);
  endtask

  task automatic setup_regs(input logic [DIM_W-1:0] mode_word, input logic [DIM_W-1:0] wv,
                            input logic [DIM_W-1:0] hv);
    write_reg(CFG_MODE, mode_word);
    write_reg(CFG_WIDTH, wv);
    write_reg(CFG_HEIGHT, hv);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering, wait for every pending pixel, then let the pipe settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Main sequence
  initial begin
    int unsigned      goal;
    bit               squeezed;
    logic [DIM_W-1:0] mode_word, w_word, h_word;

    sb = new();
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_MODE;
    cfg_wdata <= '0;
    calm      = 1'b0;
    squeeze   = 1'b0;
    squeezed  = 1'b0;
    gap_odds  = 4;
    cycle_count = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset sizes: a few pixels, nothing reaches the output yet
    for (int i = 0; i < 10; i++) send_pixel(pick_red(), i == 4);
    wait_drained();

    // dilate, sizes below range saturate to 5x5; one counted hit, at the center
    mode_word = DIM_W'($urandom);
    mode_word[0] = MODE_DILATE;
    setup_regs(mode_word, 12'd0, 12'd3);
    for (int i = 0; i < 25; i++) begin
      if (i == 3) send_pixel(HIT_LEVEL, 1'b1);
      send_pixel((i == 12 || i == 6) ? HIT_LEVEL : ((i == 17) ? 8'd254 : MISS_LEVEL), 1'b0);
    end
    for (int i = 0; i < 12; i++) send_pixel(HIT_LEVEL, i != 5);
    wait_drained();

    // erode: one zero at the center, zero on the border does not count
    setup_regs({11'h7FF, MODE_ERODE}, 12'd5, 12'd5);
    for (int i = 0; i < 25; i++)
      send_pixel((i == 12 || i == 0) ? MISS_LEVEL : ((i == 13) ? 8'd1 : HIT_LEVEL), 1'b0);
    for (int i = 0; i < 12; i++) send_pixel(MISS_LEVEL, 1'b1);
    wait_drained();

    // widest line and tallest frame: the column count runs far along row 0
    setup_regs({11'h000, MODE_DILATE}, 12'd2048, 12'd4095);
    gap_odds = 0;
    for (int i = 0; i < 256; i++)
      send_pixel(pick_red(), $urandom_range(0, 31) == 0);
    wait_drained();

    // random phases
    goal = sb.used_count + RAND_ITEMS;
    while (sb.used_count < goal) begin
      if (sb.used_count + 300 > goal) calm = 1'b1;
      case ($urandom_range(0, 2))
        0:       gap_odds = 0;
        1:       gap_odds = 3;
        default: gap_odds = 12;
      endcase
      if (calm) gap_odds = 0;
      mode_word = DIM_W'($urandom);

      if (!squeezed && sb.used_count + RAND_ITEMS > goal + 400) begin
        // receiver holds off long while frames keep coming
        setup_regs(mode_word, 12'd12, 12'd10);
        squeeze  = 1'b1;
        squeezed = 1'b1;
        repeat (3) send_frame(1'b0);
      end else if ($urandom_range(0, 7) == 0 && sb.frame_cols() <= 16 &&
                   sb.frame_rows() <= 16) begin
        // spare index: no restart, the frame carries on where it stopped
        write_reg(CFG_SPARE, DIM_W'($urandom));
        cfg_valid <= 1'b0;
        send_frame($urandom_range(0, 1) == 1);
      end else begin
        case ($urandom_range(0, 9))
          0:       w_word = DIM_W'($urandom_range(0, 4));
          1:       w_word = DIM_W'($urandom_range(2049, 4095));
          default: w_word = DIM_W'($urandom_range(5, 12));
        endcase
        case ($urandom_range(0, 9))
          0:       h_word = DIM_W'($urandom_range(0, 4));
          1:       h_word = DIM_W'($urandom_range(4090, 4095));
          default: h_word = DIM_W'($urandom_range(5, 10));
        endcase
        setup_regs(mode_word, w_word, h_word);
        if (sb.frame_cols() > 16)
          repeat ($urandom_range(10, 60)) send_pixel(pick_red(), $urandom_range(0, 7) == 0);
        else if (sb.frame_rows() > 16)
          repeat ($urandom_range(20, 300)) send_pixel(pick_red(), $urandom_range(0, 7) == 0);
        else
          repeat ($urandom_range(1, 3)) send_frame($urandom_range(0, 4) == 0);
      end
      wait_drained();
    end

    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
